### hw/rtl/scbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and constants of the size class buffer pool: field widths,
// configuration register map, result status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scbp_pkg;

  localparam int NUM_CLASSES_DEF = 4;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 26;
  localparam int CNT_W      = 9;
  localparam int STATUS_W   = 3;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = LEN_W;

  localparam int CFG_SIZE_BASE  = 0;
  localparam int CFG_COUNT_BASE = 4;
  localparam int CFG_CLASS_REGS = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_POPPED     = 3'd0,
    ST_FRESH      = 3'd1,
    ST_ALLOC_OVER = 3'd2,
    ST_PUSHED     = 3'd3,
    ST_FULL       = 3'd4,
    ST_NULL       = 3'd5,
    ST_FREE_OVER  = 3'd6
  } scbp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_POP
  } scbp_state_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic finish;
  } scbp_cmd_t;

  typedef struct packed {
    logic pop;
  } scbp_sts_t;

endpackage
`default_nettype wire

### hw/rtl/size_class_buffer_pool.sv
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_buffer_pool
// A transaction is taken when start is high and busy is low. Allocate and
// free requests that do not pop a stack pass through the evaluation state,
// and their result is registered and appears with done; a pop also passes
// through the pop state because the descriptor comes from the registered
// read port of the stack memory. Busy is low again in the cycle that done is
// high, so a new transaction can be started right then. Each result is valid
// on the result ports in the cycle that done is high and cannot be stalled.
// Configuration writes are always ready and must only be issued while idle.
// ----------------------------------------------------------------------------
module size_class_buffer_pool
  import scbp_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  func,
  input  wire logic [LEN_W-1:0]      req_len,
  input  wire logic [ADDR_W-1:0]     buf_addr,
  input  wire logic [LEN_W-1:0]      buf_len,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [CLASS_W-1:0]         class_index,
  output logic [ADDR_W-1:0]          out_addr,
  output logic [LEN_W-1:0]           out_len,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  scbp_cmd_t cmd;
  scbp_sts_t sts;

  scbp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  scbp_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .req_len     (req_len),
    .buf_addr    (buf_addr),
    .buf_len     (buf_len),
    .done        (done),
    .status      (status),
    .class_index (class_index),
    .out_addr    (out_addr),
    .out_len     (out_len)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not raise busy");

  a_no_class_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_ALLOC_OVER || status == ST_NULL ||
              status == ST_FREE_OVER))
    |-> (class_index == '0 && out_addr == '0 && out_len == '0))
    else $error("unused result fields not zero");

  a_pushed_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_PUSHED) |-> (out_addr == '0 && out_len == '0))
    else $error("push result carries data");

endmodule
`default_nettype wire

### hw/rtl/scbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_ctrl
// Controller: sequences one transaction through capture, evaluation and,
// for a pop, the stack read.
// ----------------------------------------------------------------------------
module scbp_ctrl
  import scbp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  output scbp_cmd_t      cmd,
  input  wire scbp_sts_t sts
);

  scbp_state_t state;
  scbp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.pop) begin
          state_next = S_POP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/scbp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_datapath
// Datapath: configuration registers, class search, per-class fill counts,
// descriptor stack memory and result registers.
// ----------------------------------------------------------------------------
module scbp_datapath
  import scbp_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire scbp_cmd_t             cmd,
  output scbp_sts_t                  sts,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  func,
  input  wire logic [LEN_W-1:0]      req_len,
  input  wire logic [ADDR_W-1:0]     buf_addr,
  input  wire logic [LEN_W-1:0]      buf_len,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [CLASS_W-1:0]         class_index,
  output logic [ADDR_W-1:0]          out_addr,
  output logic [LEN_W-1:0]           out_len
);

  localparam int KW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW      = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH   = NUM_CLASSES * STACK_DEPTH;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAPW    = (FW > CNT_W) ? FW : CNT_W;
  localparam int ENTRY_W = ADDR_W + LEN_W;

  logic [LEN_W-1:0]   class_size  [NUM_CLASSES];
  logic [CNT_W-1:0]   class_count [NUM_CLASSES];
  logic [FW-1:0]      fill        [NUM_CLASSES];
  logic [ENTRY_W-1:0] mem         [DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic               func_q;
  logic [LEN_W-1:0]   req_len_q;
  logic [ADDR_W-1:0]  buf_addr_q;
  logic [LEN_W-1:0]   buf_len_q;

  scbp_status_t       status_q;
  logic [KW-1:0]      class_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   len_q;

  logic [LEN_W-1:0]   search_len;
  logic               hit;
  logic               stop;
  logic [KW-1:0]      k_sel;
  logic [FW-1:0]      fill_sel;
  logic [CAPW-1:0]    cap_sel;
  logic               full;
  logic [PW-1:0]      pos;
  logic [AW-1:0]      mem_addr;
  logic               do_pop;
  logic               do_push;
  scbp_status_t       res_status;
  logic [KW-1:0]      res_class;
  logic [ADDR_W-1:0]  res_addr;
  logic [LEN_W-1:0]   res_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        class_size[k]  <= '0;
        class_count[k] <= '0;
      end
    end else if (cfg_valid) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (k < CFG_CLASS_REGS) begin
          if (cfg_index == CFG_IDX_W'(CFG_SIZE_BASE + k)) begin
            class_size[k] <= cfg_data[LEN_W-1:0];
          end
          if (cfg_index == CFG_IDX_W'(CFG_COUNT_BASE + k)) begin
            class_count[k] <= cfg_data[CNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q     <= func;
      req_len_q  <= req_len;
      buf_addr_q <= buf_addr;
      buf_len_q  <= buf_len;
    end
  end

  always_comb begin
    search_len = func_q ? buf_len_q : req_len_q;
    hit        = 1'b0;
    stop       = 1'b0;
    k_sel      = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (!hit && !stop) begin
        if (class_count[k] == '0) begin
          stop = 1'b1;
        end else if (search_len <= class_size[k]) begin
          hit   = 1'b1;
          k_sel = KW'(k);
        end
      end
    end

    fill_sel = fill[k_sel];
    cap_sel  = (CAPW'(class_count[k_sel]) > CAPW'(STACK_DEPTH)) ?
               CAPW'(STACK_DEPTH) : CAPW'(class_count[k_sel]);
    full     = CAPW'(fill_sel) >= cap_sel;
    pos      = PW'(func_q ? fill_sel : (fill_sel - FW'(1)));
    mem_addr = AW'(k_sel) * AW'(STACK_DEPTH) + AW'(pos);

    do_pop     = 1'b0;
    do_push    = 1'b0;
    res_status = ST_ALLOC_OVER;
    res_class  = '0;
    res_addr   = '0;
    res_len    = '0;
    if (!func_q) begin
      if (hit) begin
        res_class = k_sel;
        if (fill_sel == '0) begin
          res_status = ST_FRESH;
          res_len    = class_size[k_sel];
        end else begin
          res_status = ST_POPPED;
          do_pop     = 1'b1;
        end
      end
    end else if (buf_addr_q == '0) begin
      res_status = ST_NULL;
    end else if (!hit) begin
      res_status = ST_FREE_OVER;
    end else begin
      res_class = k_sel;
      if (full) begin
        res_status = ST_FULL;
        res_addr   = buf_addr_q;
      end else begin
        res_status = ST_PUSHED;
        do_push    = 1'b1;
      end
    end
  end

  assign sts.pop = do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        fill[k] <= '0;
      end
    end else if (cmd.eval) begin
      if (do_push) begin
        fill[k_sel] <= fill_sel + FW'(1);
      end else if (do_pop) begin
        fill[k_sel] <= fill_sel - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && do_push) begin
      mem[mem_addr] <= {buf_len_q, buf_addr_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && do_pop) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.eval && !do_pop) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      class_q <= res_class;
      if (!do_pop) begin
        status_q <= res_status;
        addr_q   <= res_addr;
        len_q    <= res_len;
      end
    end
    if (cmd.finish) begin
      status_q <= ST_POPPED;
      addr_q   <= rd_data[ADDR_W-1:0];
      len_q    <= rd_data[ENTRY_W-1:ADDR_W];
    end
  end

  assign status      = status_q;
  assign class_index = CLASS_W'(class_q);
  assign out_addr    = addr_q;
  assign out_len     = len_q;

endmodule
`default_nettype wire
